@@ rtl/cp_tensor_sgd_update_assert.svh @@
// Assertion macros used by the checker file.
`ifndef CP_TENSOR_SGD_UPDATE_ASSERT_SVH
`define CP_TENSOR_SGD_UPDATE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CTS_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl failed");
// Next-cycle implication checked outside reset.
`define CTS_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl failed");
`endif

@@ rtl/cts_pkg.sv @@
// Package with payload types, codes and fixed-point helpers for the SGD block.
package cts_pkg;
  localparam int unsigned DefUserRows = 1024;
  localparam int unsigned DefItemRows = 1024;
  localparam int unsigned DefContextRows = 1024;
  localparam int unsigned DefRank = 64;
  localparam int unsigned RegW = 25;
  localparam logic [RegW-1:0] LearnRateReset = 25'd3355;
  localparam logic [RegW-1:0] RegularizationReset = 25'd335544;

  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeTrain = 2'd1;
  localparam logic [1:0] ModePredict = 2'd2;
  localparam logic [1:0] ModeRead = 2'd3;
  localparam logic [1:0] SelUser = 2'd0;
  localparam logic [1:0] SelItem = 2'd1;
  localparam logic [1:0] SelContext = 2'd2;
  localparam logic CfgLearnRate = 1'b0;
  localparam logic CfgRegularization = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] matrix_select;
    logic [9:0] entry_row;
    logic [5:0] rank_index;
    logic signed [31:0] factor_value;
    logic [9:0] user_index;
    logic [9:0] item_index;
    logic [9:0] context_index;
    logic signed [31:0] rating;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] predicted;
    logic signed [31:0] residual;
    logic signed [31:0] readback_value;
    logic sample_skipped;
  } out_beat_t;

  // Multiplier operand sources.
  typedef enum logic [2:0] {
    OpUser, OpItem, OpCtx, OpResid, OpProd, OpLr, OpLam
  } op_sel_t;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    DpNop, DpReadRank, DpMulAB, DpMulPC, DpAccum, DpFinish,
    DpMulRB, DpMulPCg, DpMulLamU, DpMulLrU, DpWrU,
    DpMulRA, DpMulLamI, DpMulLrI, DpWrI, DpMulCtxTail
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic [2:0] tgt;   // 0 user, 1 item, 2 context for update steps
  } dp_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rounded Q7.24 product with saturation, input is the exact 66-bit product.
  function automatic logic signed [31:0] qround(input logic signed [65:0] p);
    logic signed [65:0] q;
    q = (p + 66'sd8388608) >>> 24;
    return sat32(q);
  endfunction
endpackage

@@ rtl/cts_ctrl.sv @@
// Controller state machine sequencing loads, reads, prediction and updates.
module cts_ctrl
  import cts_pkg::*;
#(
  parameter int unsigned RANK = DefRank
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] mode,
  input  logic rating_pos,
  output logic busy,
  output logic [$clog2(RANK+1)-1:0] rank_cnt,
  output dp_cmd_t cmd,
  output logic done
);
  localparam int unsigned CntW = $clog2(RANK+1);
  typedef enum logic [4:0] {
    Idle, Single, PRead, PMulAB, PMulPC, PAcc, PFin,
    URead, UMulRB, UMulPC, ULam, ULr, UWr,
    IMulRA, IMulPC, ILam, ILr, IWr,
    CMulRB, CMulPA, CLam, CLr, CWr, Done
  } state_t;
  state_t state;
  logic train;
  logic [CntW-1:0] cnt;
  logic last;
  assign last = (cnt == CntW'(RANK-1));
  assign rank_cnt = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle; busy <= 1'b0; done <= 1'b0; cnt <= '0; train <= 1'b0;
      cmd <= '{op: DpNop, tgt: 3'd0};
    end else begin
      done <= 1'b0;
      cmd <= '{op: DpNop, tgt: 3'd0};
      case (state)
        Idle: if (start) begin
          busy <= 1'b1; cnt <= '0; train <= (mode == ModeTrain);
          if (mode == ModeLoad || mode == ModeRead || !rating_pos) begin
            state <= Single; cmd.op <= DpReadRank;
          end else begin
            state <= PRead; cmd.op <= DpReadRank;
          end
        end
        Single: begin state <= Done; cmd.op <= DpFinish; end
        PRead: begin state <= PMulAB; cmd.op <= DpMulAB; end
        PMulAB: begin state <= PMulPC; cmd.op <= DpMulPC; end
        PMulPC: begin state <= PAcc; cmd.op <= DpAccum; end
        PAcc: if (last) begin
          state <= PFin; cmd.op <= DpFinish; cnt <= '0;
        end else begin
          cnt <= cnt + 1'b1; state <= PRead; cmd.op <= DpReadRank;
        end
        PFin: if (train) begin
          state <= URead; cmd.op <= DpReadRank;
        end else begin
          state <= Done;
        end
        URead: begin state <= UMulRB; cmd.op <= DpMulRB; end
        UMulRB: begin state <= UMulPC; cmd.op <= DpMulPCg; cmd.tgt <= 3'd0; end
        UMulPC: begin state <= ULam; cmd.op <= DpMulLamU; cmd.tgt <= 3'd0; end
        ULam: begin state <= ULr; cmd.op <= DpMulLrU; cmd.tgt <= 3'd0; end
        ULr: begin state <= UWr; cmd.op <= DpWrU; cmd.tgt <= 3'd0; end
        UWr: begin state <= IMulRA; cmd.op <= DpMulRA; end
        IMulRA: begin state <= IMulPC; cmd.op <= DpMulPCg; cmd.tgt <= 3'd1; end
        IMulPC: begin state <= ILam; cmd.op <= DpMulLamI; cmd.tgt <= 3'd1; end
        ILam: begin state <= ILr; cmd.op <= DpMulLrI; cmd.tgt <= 3'd1; end
        ILr: begin state <= IWr; cmd.op <= DpWrI; cmd.tgt <= 3'd1; end
        IWr: begin state <= CMulRB; cmd.op <= DpMulRB; cmd.tgt <= 3'd2; end
        CMulRB: begin state <= CMulPA; cmd.op <= DpMulCtxTail; cmd.tgt <= 3'd2; end
        CMulPA: begin state <= CLam; cmd.op <= DpMulLamI; cmd.tgt <= 3'd2; end
        CLam: begin state <= CLr; cmd.op <= DpMulLrI; cmd.tgt <= 3'd2; end
        CLr: begin state <= CWr; cmd.op <= DpWrI; cmd.tgt <= 3'd2; end
        CWr: if (last) begin
          state <= Done;
        end else begin
          cnt <= cnt + 1'b1; state <= URead; cmd.op <= DpReadRank;
        end
        Done: begin state <= Idle; busy <= 1'b0; done <= 1'b1; end
        default: state <= Idle;
      endcase
    end
  end
endmodule

@@ rtl/cts_datapath.sv @@
// Datapath: factor memories, a shared multiplier plus dedicated product logic, accumulator and update logic.
module cts_datapath
  import cts_pkg::*;
#(
  parameter int unsigned USER_ROWS = DefUserRows,
  parameter int unsigned ITEM_ROWS = DefItemRows,
  parameter int unsigned CONTEXT_ROWS = DefContextRows,
  parameter int unsigned RANK = DefRank
) (
  input  logic clk,
  input  logic start_acc,
  input  in_beat_t in_beat,
  input  logic [RegW-1:0] learn_rate,
  input  logic [RegW-1:0] regularization,
  input  logic [$clog2(RANK+1)-1:0] rank_cnt,
  input  dp_cmd_t cmd,
  output out_beat_t out_beat
);
  localparam int unsigned RkW = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int unsigned UaW = $clog2(USER_ROWS * RANK);
  localparam int unsigned IaW = $clog2(ITEM_ROWS * RANK);
  localparam int unsigned CaW = $clog2(CONTEXT_ROWS * RANK);

  logic [31:0] umem [USER_ROWS*RANK];
  logic [31:0] imem [ITEM_ROWS*RANK];
  logic [31:0] cmem [CONTEXT_ROWS*RANK];

  in_beat_t ib;
  logic signed [31:0] a, b, c, resid, prod, g;
  logic signed [71:0] acc;
  logic signed [31:0] ru, ri, rc;
  logic uok, iok, cok, eok;
  logic [RkW-1:0] rk;
  logic [UaW-1:0] ua, ea_u;
  logic [IaW-1:0] ia, ea_i;
  logic [CaW-1:0] ca, ea_c;
  logic signed [32:0] m1, m2;
  logic signed [65:0] mp;
  logic signed [31:0] mq;
  logic signed [31:0] upd, own;

  assign rk = rank_cnt[RkW-1:0];
  assign uok = 32'(ib.user_index) < USER_ROWS;
  assign iok = 32'(ib.item_index) < ITEM_ROWS;
  assign cok = 32'(ib.context_index) < CONTEXT_ROWS;
  assign ua = UaW'(32'(ib.user_index) * RANK + 32'(rk));
  assign ia = IaW'(32'(ib.item_index) * RANK + 32'(rk));
  assign ca = CaW'(32'(ib.context_index) * RANK + 32'(rk));
  assign ea_u = UaW'(32'(ib.entry_row) * RANK + 32'(ib.rank_index));
  assign ea_i = IaW'(32'(ib.entry_row) * RANK + 32'(ib.rank_index));
  assign ea_c = CaW'(32'(ib.entry_row) * RANK + 32'(ib.rank_index));
  assign eok = 32'(ib.rank_index) < RANK;

  // Shared multiplier operand selection.
  always_comb begin
    m1 = '0; m2 = '0;
    case (cmd.op)
      DpMulAB:      begin m1 = 33'(a); m2 = 33'(b); end
      DpMulPC:      begin m1 = 33'(prod); m2 = 33'(c); end
      DpMulRB:      begin m1 = 33'(resid); m2 = (cmd.tgt == 3'd2) ? 33'(b) : 33'(b); end
      DpMulRA:      begin m1 = 33'(resid); m2 = 33'(a); end
      DpMulPCg:     begin m1 = 33'(prod); m2 = 33'(c); end
      DpMulCtxTail: begin m1 = 33'(prod); m2 = 33'(a); end
      DpMulLamU, DpMulLamI: begin
        m1 = 33'({1'b0, regularization});
        m2 = (cmd.tgt == 3'd0) ? 33'(a) : (cmd.tgt == 3'd1) ? 33'(b) : 33'(c);
      end
      DpMulLrU, DpMulLrI: begin m1 = 33'({1'b0, learn_rate}); m2 = 33'(g); end
      default: begin m1 = '0; m2 = '0; end
    endcase
    mp = 66'(m1) * 66'(m2);
    mq = qround(mp);
    own = (cmd.tgt == 3'd0) ? a : (cmd.tgt == 3'd1) ? b : c;
    upd = sat32(66'(own) + 66'(prod));
  end

  always_ff @(posedge clk) begin
    if (start_acc) ib <= in_beat;
    ru <= umem[ua]; ri <= imem[ia]; rc <= cmem[ca];
    case (cmd.op)
      DpReadRank: begin
        out_beat.readback_value <= '0;
        if (rank_cnt == '0 && !start_acc) acc <= '0;
      end
      DpMulAB: begin
        a <= uok ? ru : '0; b <= iok ? ri : '0; c <= cok ? rc : '0;
        prod <= qround(66'(uok ? ru : 32'sd0) * 66'(iok ? ri : 32'sd0));
      end
      DpMulPC: prod <= mq;
      DpAccum: acc <= acc + 72'(prod);
      DpFinish: begin
        out_beat.predicted <= '0; out_beat.residual <= '0;
        out_beat.readback_value <= '0; out_beat.sample_skipped <= 1'b0;
        if (ib.mode == ModeLoad) begin
          if (eok && 32'(ib.entry_row) < USER_ROWS && ib.matrix_select == SelUser)
            umem[ea_u] <= ib.factor_value;
          if (eok && 32'(ib.entry_row) < ITEM_ROWS && ib.matrix_select == SelItem)
            imem[ea_i] <= ib.factor_value;
          if (eok && 32'(ib.entry_row) < CONTEXT_ROWS && ib.matrix_select == SelContext)
            cmem[ea_c] <= ib.factor_value;
        end else if (ib.mode == ModeRead) begin
          if (eok && ib.matrix_select == SelUser && 32'(ib.entry_row) < USER_ROWS)
            out_beat.readback_value <= umem[ea_u];
          else if (eok && ib.matrix_select == SelItem && 32'(ib.entry_row) < ITEM_ROWS)
            out_beat.readback_value <= imem[ea_i];
          else if (eok && ib.matrix_select == SelContext &&
                   32'(ib.entry_row) < CONTEXT_ROWS)
            out_beat.readback_value <= cmem[ea_c];
        end else if (ib.rating <= 0) begin
          out_beat.sample_skipped <= 1'b1;
        end else begin
          out_beat.predicted <= sat32(acc[65:0]);
          out_beat.residual <= sat32(66'(ib.rating) - 66'(sat32(acc[65:0])));
          resid <= sat32(66'(ib.rating) - 66'(sat32(acc[65:0])));
        end
      end
      DpMulRB: begin
        if (cmd.tgt != 3'd2) begin
          a <= uok ? ru : '0; b <= iok ? ri : '0; c <= cok ? rc : '0;
          prod <= qround(66'(resid) * 66'(iok ? ri : 32'sd0));
        end else prod <= mq;
      end
      DpMulRA: prod <= mq;
      // Both gradient tails double the rounded product into g.
      DpMulPCg, DpMulCtxTail: g <= sat32(66'(mq) * 66'sd2);
      DpMulLamU, DpMulLamI: g <= sat32(66'(g) - 66'(mq));
      DpMulLrU, DpMulLrI: prod <= mq;
      DpWrU: begin
        a <= upd;
        if (uok) umem[ua] <= upd;
      end
      DpWrI: begin
        if (cmd.tgt == 3'd1) begin
          b <= upd; if (iok) imem[ia] <= upd;
        end else begin
          c <= upd; if (cok) cmem[ca] <= upd;
        end
      end
      default: ;
    endcase
    if (start_acc) acc <= '0;
  end
endmodule

@@ rtl/cp_tensor_sgd_update.sv @@
// Top level of the CP tensor factorization SGD block.
// A new beat is accepted only while busy is low, so the block finishes one beat
// before it takes the next; busy drops in the done cycle, no stalls.
// rst is synchronous, active high; factor memories are not cleared.
module cp_tensor_sgd_update
  import cts_pkg::*;
#(
  parameter int unsigned USER_ROWS = DefUserRows,
  parameter int unsigned ITEM_ROWS = DefItemRows,
  parameter int unsigned CONTEXT_ROWS = DefContextRows,
  parameter int unsigned RANK = DefRank
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_beat_t in_data,
  output logic done,
  output out_beat_t out_data,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [RegW-1:0] cfg_data
);
  logic [RegW-1:0] learn_rate, regularization;
  logic [$clog2(RANK+1)-1:0] rank_cnt;
  dp_cmd_t cmd;
  logic accept;
  assign accept = start && !busy;

  // Configuration registers, to be written only while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LearnRateReset;
      regularization <= RegularizationReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgLearnRate) learn_rate <= cfg_data;
      else regularization <= cfg_data;
    end
  end

  cts_ctrl #(.RANK(RANK)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(in_data.mode),
    .rating_pos(in_data.rating > 0), .busy(busy), .rank_cnt(rank_cnt),
    .cmd(cmd), .done(done)
  );

  cts_datapath #(
    .USER_ROWS(USER_ROWS), .ITEM_ROWS(ITEM_ROWS),
    .CONTEXT_ROWS(CONTEXT_ROWS), .RANK(RANK)
  ) u_dp (
    .clk(clk), .start_acc(accept), .in_beat(in_data), .learn_rate(learn_rate),
    .regularization(regularization), .rank_cnt(rank_cnt), .cmd(cmd),
    .out_beat(out_data)
  );
endmodule

@@ rtl/cts_checker.sv @@
// Port-level checker for the SGD block and its bind.
`include "cp_tensor_sgd_update_assert.svh"
module cts_checker
  import cts_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input out_beat_t out_data
);
  `CTS_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `CTS_ASSERT_NEXT(a_done_idle, clk, rst, done, !done)
  `CTS_ASSERT_IMP(a_skip_zero, clk, rst, done && out_data.sample_skipped,
    out_data.predicted == 0 && out_data.residual == 0)
endmodule

bind cp_tensor_sgd_update cts_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .out_data(out_data)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the CP tensor factorization SGD block.
`timescale 1ns / 100ps

// Scoreboard: keeps its own copy of the three factor memories and the two
// registers, predicts the result of each accepted beat, and checks results in order.
class sgd_scoreboard;
  logic signed [31:0] factor_mem [int];
  logic [24:0] step_size;
  logic [24:0] decay;
  cts_pkg::out_beat_t expected_q [$];
  int mismatches;

  function new();
    step_size = cts_pkg::LearnRateReset;
    decay = cts_pkg::RegularizationReset;
    mismatches = 0;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rounded Q7.24 product: add half an LSB, then floor by the arithmetic shift.
  function automatic longint fix_mul(longint a, longint b);
    longint p;
    p = a * b + 64'sd8388608;
    return clamp32(p >>> 24);
  endfunction

  function automatic int slot(int sel, int row, int rank);
    return sel * 65536 + row * 64 + rank;
  endfunction

  function automatic longint fetch(int sel, int row, int rank);
    int k;
    k = slot(sel, row, rank);
    if (!factor_mem.exists(k)) return 0;
    return longint'(factor_mem[k]);
  endfunction

  function void store(int sel, int row, int rank, longint v);
    factor_mem[slot(sel, row, rank)] = v[31:0];
  endfunction

  function void set_reg(logic idx, logic [24:0] v);
    if (idx == cts_pkg::CfgLearnRate) step_size = v;
    else decay = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Works out the result of one accepted beat and updates the factor copies.
  function void note_input(cts_pkg::in_beat_t b);
    cts_pkg::out_beat_t r;
    longint acc, resid, pred, ua, ib, cc, g, d, lr, lam;
    r = '0;
    if (b.mode == cts_pkg::ModeLoad || b.mode == cts_pkg::ModeRead) begin
      if (b.matrix_select != 2'd3) begin
        if (b.mode == cts_pkg::ModeLoad)
          store(b.matrix_select, b.entry_row, b.rank_index, longint'(b.factor_value));
        else
          r.readback_value = 32'(fetch(b.matrix_select, b.entry_row, b.rank_index));
      end
    end else if (b.rating <= 0) begin
      r.sample_skipped = 1'b1;
    end else begin
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        acc += fix_mul(fix_mul(fetch(cts_pkg::SelUser, b.user_index, k),
                               fetch(cts_pkg::SelItem, b.item_index, k)),
                       fetch(cts_pkg::SelContext, b.context_index, k));
      end
      pred = clamp32(acc);
      resid = clamp32(longint'(b.rating) - pred);
      r.predicted = pred[31:0];
      r.residual = resid[31:0];
      if (b.mode == cts_pkg::ModeTrain) begin
        lr = longint'(step_size);
        lam = longint'(decay);
        // Each rank updates user first, then item with the fresh user value,
        // then context with both fresh values.
        for (int k = 0; k < 64; k++) begin
          ua = fetch(cts_pkg::SelUser, b.user_index, k);
          ib = fetch(cts_pkg::SelItem, b.item_index, k);
          cc = fetch(cts_pkg::SelContext, b.context_index, k);
          g = clamp32(2 * fix_mul(fix_mul(resid, ib), cc));
          d = clamp32(g - fix_mul(lam, ua));
          ua = clamp32(ua + fix_mul(lr, d));
          store(cts_pkg::SelUser, b.user_index, k, ua);
          g = clamp32(2 * fix_mul(fix_mul(resid, ua), cc));
          d = clamp32(g - fix_mul(lam, ib));
          ib = clamp32(ib + fix_mul(lr, d));
          store(cts_pkg::SelItem, b.item_index, k, ib);
          g = clamp32(2 * fix_mul(fix_mul(resid, ib), ua));
          d = clamp32(g - fix_mul(lam, cc));
          cc = clamp32(cc + fix_mul(lr, d));
          store(cts_pkg::SelContext, b.context_index, k, cc);
        end
      end
    end
    expected_q.push_back(r);
  endfunction

  function void check_result(cts_pkg::out_beat_t got);
    cts_pkg::out_beat_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result beat: %p", got);
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Mismatch: expected pred=%0d resid=%0d rb=%0d skip=%0b, ",
                  "got pred=%0d resid=%0d rb=%0d skip=%0b"},
                 want.predicted, want.residual, want.readback_value, want.sample_skipped,
                 got.predicted, got.residual, got.readback_value, got.sample_skipped);
    end
  endfunction
endclass

module testbench
  import cts_pkg::*;
();

  localparam int StallLimit = 8000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_beat_t in_data;
  logic done;
  out_beat_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [RegW-1:0] cfg_data;

  sgd_scoreboard sb;
  // Rows that are fully written in all three factor memories, so that train
  // and predict beats never read an entry that was never written.
  int row_pool [3] = '{0, 682, 1023};
  // Written entries, as (select, row, rank) keys, for choosing read addresses.
  int written_q [$];
  bit gaps_on;
  int quiet_cycles;

  cp_tensor_sgd_update dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_data(in_data),
    .done(done), .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every result beat is checked at the edge that ends its strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(out_data);
  end

  // The watchdog ends a run in which nothing moves for too long.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_factor();
    int c;
    c = $urandom_range(99);
    if (c < 80) return $signed($urandom_range(0, 32'h2000000)) - 32'sh1000000;
    if (c < 85) return 32'sh7fffffff;
    if (c < 90) return 32'sh80000000;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_rating();
    int c;
    c = $urandom_range(99);
    if (c < 65) return $urandom_range(1, 32'h5000000);
    if (c < 72) return 32'sd0;
    if (c < 80) return -$signed($urandom_range(1, 32'h5000000));
    if (c < 85) return 32'sh7fffffff;
    if (c < 88) return 32'sh80000000;
    if (c < 90) return 32'sd1;
    return $urandom;
  endfunction

  // A beat with every field random; callers overwrite the fields that matter.
  function automatic in_beat_t noise_beat();
    in_beat_t b;
    b.mode = 2'($urandom);
    b.matrix_select = 2'($urandom);
    b.entry_row = 10'($urandom);
    b.rank_index = 6'($urandom);
    b.factor_value = $urandom;
    b.user_index = 10'($urandom);
    b.item_index = 10'($urandom);
    b.context_index = 10'($urandom);
    b.rating = $urandom;
    return b;
  endfunction

  task automatic send_beat(in_beat_t b);
    if (gaps_on && $urandom_range(99) < 17) repeat ($urandom_range(1, 6)) @(negedge clk);
    @(negedge clk);
    start = 1'b1;
    in_data = b;
    do @(posedge clk); while (busy);
    sb.note_input(b);
    if (b.mode == ModeLoad && b.matrix_select != 2'd3)
      written_q.push_back(b.matrix_select * 65536 + b.entry_row * 64 + b.rank_index);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic load_entry(logic [1:0] sel, logic [9:0] row, logic [5:0] rank,
                            logic signed [31:0] v);
    in_beat_t b;
    b = noise_beat();
    b.mode = ModeLoad;
    b.matrix_select = sel;
    b.entry_row = row;
    b.rank_index = rank;
    b.factor_value = v;
    send_beat(b);
  endtask

  task automatic read_written();
    in_beat_t b;
    int k;
    k = written_q[$urandom_range(written_q.size() - 1)];
    b = noise_beat();
    b.mode = ModeRead;
    b.matrix_select = 2'(k / 65536);
    b.entry_row = 10'((k % 65536) / 64);
    b.rank_index = 6'(k % 64);
    send_beat(b);
  endtask

  task automatic rate_sample(logic [1:0] mode, logic signed [31:0] rating);
    in_beat_t b;
    b = noise_beat();
    b.mode = mode;
    b.user_index = 10'(row_pool[$urandom_range(2)]);
    b.item_index = 10'(row_pool[$urandom_range(2)]);
    b.context_index = 10'(row_pool[$urandom_range(2)]);
    b.rating = rating;
    send_beat(b);
  endtask

  // Hold the sender back until every expected beat has come and the block is idle.
  task automatic drain();
    do @(posedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic write_reg(logic idx, logic [RegW-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_phase(int count);
    in_beat_t b;
    int c;
    for (int n = 0; n < count; n++) begin
      c = $urandom_range(99);
      if (c < 22) begin
        // Loads mostly refresh the pool rows so training data stays varied.
        if ($urandom_range(3) == 0)
          load_entry(2'($urandom_range(2)), 10'($urandom), 6'($urandom), pick_factor());
        else
          load_entry(2'($urandom_range(2)), 10'(row_pool[$urandom_range(2)]),
                     6'($urandom), pick_factor());
      end else if (c < 45) begin
        read_written();
      end else if (c < 70) begin
        rate_sample(ModeTrain, pick_rating());
      end else if (c < 94) begin
        rate_sample(ModePredict, pick_rating());
      end else begin
        b = noise_beat();
        b.mode = $urandom_range(1) ? ModeLoad : ModeRead;
        b.matrix_select = 2'd3;
        send_beat(b);
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CfgLearnRate;
    cfg_data = '0;
    gaps_on = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every rank of the pool rows in all three memories, with no gaps.
    for (int s = 0; s < 3; s++)
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 64; k++)
          load_entry(2'(s), 10'(row_pool[r]), 6'(k), pick_factor());

    // Directed beats: extreme values, both bad-select cases, every mode and the
    // edges of the rating, including the skip on zero and on negative ratings.
    gaps_on = 1'b1;
    load_entry(SelContext, 10'd1023, 6'd63, 32'sh7fffffff);
    load_entry(SelItem, 10'd1023, 6'd63, 32'sh80000000);
    load_entry(2'd3, 10'd5, 6'd5, 32'sh12345678);
    read_written();
    begin
      in_beat_t b;
      b = noise_beat();
      b.mode = ModeRead;
      b.matrix_select = 2'd3;
      send_beat(b);
    end
    rate_sample(ModePredict, 32'sh7fffffff);
    rate_sample(ModePredict, 32'sd1);
    rate_sample(ModePredict, 32'sd0);
    rate_sample(ModeTrain, 32'sh80000000);
    rate_sample(ModeTrain, -32'sd1);
    rate_sample(ModeTrain, 32'sh7fffffff);
    rate_sample(ModeTrain, 32'sh1000000);
    rate_sample(ModeTrain, 32'sd1);
    for (int n = 0; n < 6; n++) read_written();
    drain();

    // Register settings, extremes included; each phase starts from idle.
    write_reg(CfgLearnRate, 25'h1000000);
    write_reg(CfgRegularization, 25'd0);
    random_phase(40);
    drain();
    write_reg(CfgLearnRate, 25'd0);
    write_reg(CfgRegularization, 25'h1000000);
    random_phase(30);
    drain();
    write_reg(CfgLearnRate, 25'($urandom_range(0, 25'h1000000)));
    write_reg(CfgRegularization, 25'($urandom_range(0, 25'h1000000)));
    gaps_on = 1'b0;
    random_phase(40);
    gaps_on = 1'b1;
    drain();
    write_reg(CfgLearnRate, LearnRateReset);
    write_reg(CfgRegularization, RegularizationReset);
    random_phase(60);

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/cts_pkg.sv
rtl/cts_ctrl.sv
rtl/cts_datapath.sv
rtl/cp_tensor_sgd_update.sv
rtl/cts_checker.sv
bench/testbench.sv
